>>> src/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define SAT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/sat_pkg.sv
// Types, codes and character helpers for the shell argument tokenizer.
`default_nettype none
package sat_pkg;

   localparam logic [2:0] KIND_CHAR      = 3'd0;
   localparam logic [2:0] KIND_HOME      = 3'd1;
   localparam logic [2:0] KIND_TOKEN_END = 3'd2;
   localparam logic [2:0] KIND_DONE      = 3'd3;
   localparam logic [2:0] KIND_ERROR     = 3'd4;

   localparam logic [1:0] ERR_BAD_ESCAPE = 2'd0;
   localparam logic [1:0] ERR_SPLICE     = 2'd1;
   localparam logic [1:0] ERR_OPEN_QUOTE = 2'd2;
   localparam logic [1:0] ERR_DANGLING   = 2'd3;

   localparam logic [15:0] CH_BSLASH = 16'h005C;
   localparam logic [15:0] CH_N      = 16'h006E;
   localparam logic [15:0] CH_R      = 16'h0072;
   localparam logic [15:0] CH_T      = 16'h0074;
   localparam logic [15:0] CH_QUOTE  = 16'h0022;
   localparam logic [15:0] CH_TILDE  = 16'h007E;
   localparam logic [15:0] CH_SPACE  = 16'h0020;
   localparam logic [15:0] CH_LF     = 16'h000A;
   localparam logic [15:0] CH_CR     = 16'h000D;
   localparam logic [15:0] CH_TAB    = 16'h0009;

   // Max results one character can cause.
   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] ch;
      logic [1:0]  err;
   } result_type;

   typedef logic [1:0] count_type;

   function automatic logic is_space(input logic [15:0] c);
      logic hit;
      hit = 1'b0;
      if (c >= 16'h0009 && c <= 16'h000D) hit = 1'b1;
      if (c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) hit = 1'b1;
      if (c >= 16'h2000 && c <= 16'h200A) hit = 1'b1;
      if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F) hit = 1'b1;
      if (c == 16'h205F || c == 16'h3000) hit = 1'b1;
      return hit;
   endfunction

   // Escape translation: bit 16 flags a legal escape, low bits the mapped char.
   function automatic logic [16:0] escape_map(input logic [15:0] c);
      logic [16:0] m;
      unique case (c)
         CH_SPACE: m = {1'b1, CH_SPACE};
         CH_TILDE: m = {1'b1, CH_TILDE};
         CH_QUOTE: m = {1'b1, CH_QUOTE};
         CH_N:     m = {1'b1, CH_LF};
         CH_R:     m = {1'b1, CH_CR};
         CH_T:     m = {1'b1, CH_TAB};
         default:  m = 17'd0;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

>>> src/sat_decode.sv
// Per-character tokenizer decision and parse state.
`default_nettype none
`include "assert_macros.svh"
module sat_decode import sat_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           in_ch,
   input  wire logic                  in_eoc,
   input  wire logic                  advance,
   output      result_type [2:0]      rslt,
   output      count_type             rslt_cnt
);

   typedef struct packed {
      logic esc;
      logic inq;
      logic tok_empty;
      logic qjc;
      logic drop;
   } pstate_type;

   localparam pstate_type PSTATE_RESET = '{esc: 1'b0, inq: 1'b0, tok_empty: 1'b1,
                                           qjc: 1'b0, drop: 1'b0};

   pstate_type st_ff, st_in;
   result_type [2:0] cand;
   logic [2:0]       cand_v;
   logic             err_v;
   logic [1:0]       err_c;
   logic [16:0]      emap;

   always_comb begin
      st_in  = st_ff;
      cand   = '0;
      cand_v = '0;
      err_v  = 1'b0;
      err_c  = ERR_BAD_ESCAPE;
      emap   = escape_map(in_ch);
      if (!st_ff.drop) begin
         if (st_ff.qjc && in_ch == CH_QUOTE) begin
            err_v = 1'b1;
            err_c = ERR_SPLICE;
         end
         st_in.qjc = 1'b0;
         if (!err_v) begin
            if (in_ch == CH_BSLASH) begin
               if (st_ff.esc) begin
                  cand_v[0]       = 1'b1;
                  cand[0].kind    = KIND_CHAR;
                  cand[0].ch      = CH_BSLASH;
                  st_in.tok_empty = 1'b0;
                  st_in.esc       = 1'b0;
               end else begin
                  st_in.esc = 1'b1;
               end
            end else if (st_ff.esc) begin
               if (emap[16]) begin
                  cand_v[0]       = 1'b1;
                  cand[0].kind    = KIND_CHAR;
                  cand[0].ch      = emap[15:0];
                  st_in.tok_empty = 1'b0;
                  st_in.esc       = 1'b0;
               end else begin
                  err_v = 1'b1;
                  err_c = ERR_BAD_ESCAPE;
               end
            end else if (in_ch == CH_TILDE && !st_ff.inq && st_ff.tok_empty) begin
               cand_v[0]       = 1'b1;
               cand[0].kind    = KIND_HOME;
               st_in.tok_empty = 1'b0;
            end else if (is_space(in_ch)) begin
               if (st_ff.inq) begin
                  cand_v[0]       = 1'b1;
                  cand[0].kind    = KIND_CHAR;
                  cand[0].ch      = in_ch;
                  st_in.tok_empty = 1'b0;
               end else if (!st_ff.tok_empty) begin
                  cand_v[0]       = 1'b1;
                  cand[0].kind    = KIND_TOKEN_END;
                  st_in.tok_empty = 1'b1;
               end
            end else if (in_ch == CH_QUOTE) begin
               st_in.inq = !st_ff.inq;
               st_in.qjc = st_ff.inq;
            end else begin
               cand_v[0]       = 1'b1;
               cand[0].kind    = KIND_CHAR;
               cand[0].ch      = in_ch;
               st_in.tok_empty = 1'b0;
            end
         end
         // closing result: error, or end-of-command wrap-up
         if (err_v) begin
            cand_v[1]    = 1'b1;
            cand[1].kind = KIND_ERROR;
            cand[1].err  = err_c;
            st_in.drop   = 1'b1;
         end else if (in_eoc) begin
            if (st_in.inq) begin
               cand_v[1]    = 1'b1;
               cand[1].kind = KIND_ERROR;
               cand[1].err  = ERR_OPEN_QUOTE;
            end else if (st_in.esc) begin
               cand_v[1]    = 1'b1;
               cand[1].kind = KIND_ERROR;
               cand[1].err  = ERR_DANGLING;
            end else if (!st_in.tok_empty) begin
               cand_v[1]    = 1'b1;
               cand[1].kind = KIND_TOKEN_END;
            end
         end
      end
      if (in_eoc) begin
         cand_v[2]    = 1'b1;
         cand[2].kind = KIND_DONE;
         st_in        = PSTATE_RESET;
      end
   end

   // pack the valid candidates to the front
   always_comb begin
      rslt     = '0;
      rslt_cnt = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (cand_v[i]) begin
            rslt[rslt_cnt] = cand[i];
            rslt_cnt       = rslt_cnt + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= PSTATE_RESET;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   `SAT_ASSERT_NEXT(a_eoc_resets, advance && in_eoc, st_ff == PSTATE_RESET,
                    "parse state not cleared after end of command")
   `SAT_ASSERT(a_eoc_done_last, !(advance && in_eoc) || rslt[rslt_cnt - 2'd1].kind == KIND_DONE,
               "end of command not closed by a done result")

endmodule
`default_nettype wire

>>> src/sat_rsp_buf.sv
// Result buffer: holds one character's results and hands them out one per beat.
`default_nettype none
`include "assert_macros.svh"
module sat_rsp_buf import sat_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire result_type [2:0] load_rslt,
   input  wire count_type        load_cnt,
   output      logic             drain_ok,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      result_type       rsp_rslt,
   output      logic             rsp_last
);

   result_type [2:0] ent_ff;
   count_type        cnt_ff;
   count_type        head_ff;
   logic             fire;

   assign rsp_valid = head_ff != cnt_ff;
   assign fire      = rsp_valid && rsp_ready;
   assign rsp_rslt  = ent_ff[head_ff];
   assign rsp_last  = (head_ff + 2'd1) == cnt_ff;
   // buffer is free next cycle: empty now, or last result leaving now
   assign drain_ok  = !rsp_valid || (rsp_last && rsp_ready);

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= load_rslt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         head_ff <= '0;
      end else if (load) begin
         cnt_ff  <= load_cnt;
         head_ff <= '0;
      end else if (fire) begin
         head_ff <= head_ff + 2'd1;
      end
   end

   `SAT_ASSERT(a_head_bound, head_ff <= cnt_ff, "read pointer ran past fill count")
   `SAT_ASSERT(a_load_drained, !load || drain_ok, "buffer loaded while results pending")

endmodule
`default_nettype wire

>>> src/shell_argument_tokenizer.sv
// Top level of the shell argument tokenizer.
// Path: input register, then result buffer, then the result port.
// Throughput: one character per cycle while rsp_ready is high and each gives
//   at most one result; a character with more (up to three) holds back the next.
// Characters giving no result put no beat on the result port.
// Reset (synchronous, active high) clears the parse state and both stages.
`default_nettype none
module shell_argument_tokenizer import sat_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [15:0] req_ch,
   input  wire logic        req_end_of_command,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_result_kind,
   output      logic [15:0] rsp_char_out,
   output      logic [1:0]  rsp_error_code,
   output      logic        rsp_last_of_run
);

   // input register
   logic        in_v_ff;
   logic [15:0] in_ch_ff;
   logic        in_eoc_ff;

   logic             advance;
   logic             drain_ok;
   result_type [2:0] dec_rslt;
   count_type        dec_cnt;
   result_type       out_rslt;

   // the held character moves on once the result buffer frees up
   assign advance   = in_v_ff && drain_ok;
   assign req_ready = !in_v_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_ready) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff  <= req_ch;
         in_eoc_ff <= req_end_of_command;
      end
   end

   // decision logic and parse state; state commits as the character advances
   sat_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_ch    (in_ch_ff),
      .in_eoc   (in_eoc_ff),
      .advance  (advance),
      .rslt     (dec_rslt),
      .rslt_cnt (dec_cnt)
   );

   // result register: up to three beats per character
   sat_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_rslt (dec_rslt),
      .load_cnt  (dec_cnt),
      .drain_ok  (drain_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_rslt  (out_rslt),
      .rsp_last  (rsp_last_of_run)
   );

   assign rsp_result_kind = out_rslt.kind;
   assign rsp_char_out    = out_rslt.ch;
   assign rsp_error_code  = out_rslt.err;

endmodule
`default_nettype wire
